[design/spll_pkg.sv]
// ----------------------------------------------------------------------------
// spll_pkg
// Shared constants, register indices and helper functions for the
// single-phase SOGI phase-locked loop.
// ----------------------------------------------------------------------------
package spll_pkg;

  // Configuration register indices, one 32-bit word each.
  typedef enum logic [2:0] {
    REG_DC_OFFSET     = 3'd0,
    REG_SOGI_GAIN     = 3'd1,
    REG_NOMINAL_OMEGA = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_PROP_GAIN     = 3'd4,
    REG_INTEG_GAIN    = 3'd5
  } reg_idx_e;

  // Register reset values.
  localparam logic [14:0] DC_OFFSET_RST     = 15'd6758;
  localparam logic [15:0] SOGI_GAIN_RST     = 16'd23170;
  localparam logic [23:0] NOMINAL_OMEGA_RST = 24'd1286796;
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd429497;
  localparam logic [23:0] PROP_GAIN_RST     = 24'd3276800;
  localparam logic [27:0] INTEG_GAIN_RST    = 28'd6553600;

  // Saturation limits, all Q8.12 except TRIG_LIM, which is Q1.15.
  localparam logic signed [39:0] VIN_LIM  = 40'sd8192;
  localparam logic signed [39:0] WIDE_LIM = 40'sd8388607;
  localparam logic signed [39:0] SAT_LIM  = 40'sd409600;
  localparam logic signed [39:0] ERR_LIM  = 40'sd40960;
  localparam logic signed [39:0] OUT_LIM  = 40'sd81920;
  localparam logic signed [39:0] TRIG_LIM = 40'sd32767;
  localparam logic signed [39:0] RATE_MAX = 40'sd16777215;

  // 1/(2*pi) in Q0.32.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // Rounding offsets preloaded into the accumulator.
  localparam logic signed [71:0] RND_PHASE = 72'sd34359738368;
  localparam logic signed [71:0] RND_HZ    = 72'sd134217728;

  // Lock window.
  localparam logic [23:0]        FREQ_LO  = 24'd3263693;
  localparam logic [23:0]        FREQ_HI  = 24'd3289907;
  localparam logic signed [20:0] VQ_LIM   = 21'sd8192;
  localparam logic [19:0]        AMP_MIN  = 20'd410;
  localparam logic [23:0]        FREQ_RST = 24'd3276800;

  // Low-pass filter coefficients, Q0.16.
  localparam logic [20:0] FREQ_ALPHA = 21'd3277;
  localparam logic [20:0] AMP_ALPHA  = 21'd1311;

  // CORDIC set-up.
  localparam logic signed [25:0] CORDIC_X0   = 26'sd5094007;
  localparam logic [3:0]         CORDIC_LAST = 4'd13;
  localparam logic signed [17:0] QTR_TURN    = 18'sd16384;
  localparam logic signed [17:0] HALF_TURN   = 18'sd32768;

  // Square root walks the bit pairs from 2^38 down to 2^0.
  localparam logic [4:0] SQRT_TOP = 5'd19;

  function automatic logic [13:0] atan_turn(input logic [3:0] idx);
    logic [13:0] val;
    case (idx)
      4'd0:    val = 14'd8192;
      4'd1:    val = 14'd4836;
      4'd2:    val = 14'd2555;
      4'd3:    val = 14'd1297;
      4'd4:    val = 14'd651;
      4'd5:    val = 14'd326;
      4'd6:    val = 14'd163;
      4'd7:    val = 14'd81;
      4'd8:    val = 14'd41;
      4'd9:    val = 14'd20;
      4'd10:   val = 14'd10;
      4'd11:   val = 14'd5;
      4'd12:   val = 14'd3;
      4'd13:   val = 14'd1;
      default: val = 14'd0;
    endcase
    return val;
  endfunction

  function automatic logic signed [39:0] sat_sym(input logic signed [39:0] v,
                                                 input logic signed [39:0] lim);
    logic signed [39:0] res;
    if (v > lim) begin
      res = lim;
    end else if (v < -lim) begin
      res = -lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[design/sogi_phase_locked_loop_unit.sv]
// ----------------------------------------------------------------------------
// sogi_phase_locked_loop_unit
// Single-phase SOGI PLL in fixed point, built around one shared
// multiply-accumulate unit driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel carries one beat per item: kind_i selects an ADC sample
// step (0) or a monitor tick (1), and sample_volts_i is the ADC voltage.
// Each beat produces exactly one output beat with the phase, sine, cosine,
// angular rate, Park components, filtered frequency, filtered amplitude and
// the lock flag, all taken from the state after the update.
// The work of each beat is done by the single 33x21 multiplier, which forms
// every product as one or two partial products, by the 14-step CORDIC on a
// sample beat and by the 20-step square root on a monitor beat, each of
// which iterates one step a cycle.
// in_stall_o is high from acceptance until the result has been written to the
// output register, so the next beat is taken in the cycle after that write.
// The output register holds a finished beat while out_stall_i is high; a
// new input beat may still be accepted and worked on meanwhile, and its
// result waits in the final state until the output register is free.
// Reset clears the loop state to its documented values, restores the
// configuration registers to their defaults and drops out_valid_o. Users must
// write configuration over the APB port while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module sogi_phase_locked_loop_unit #(
  parameter int LOCK_COUNT = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] sample_volts_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] phase_o,
  output logic signed [15:0] sine_o,
  output logic signed [15:0] cosine_o,
  output logic [23:0] angular_rate_o,
  output logic signed [20:0] direct_comp_o,
  output logic signed [20:0] quad_comp_o,
  output logic [23:0] freq_hz_o,
  output logic [19:0] amplitude_o,
  output logic        locked_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spll_pkg::*;

  localparam int CNT_W = $clog2(LOCK_COUNT + 1);
  localparam logic [CNT_W-1:0] LOCK_VAL = CNT_W'(LOCK_COUNT);

  typedef enum logic [5:0] {
    ST_IDLE, ST_W0, ST_W1, ST_K0, ST_K1, ST_E, ST_D0, ST_D1, ST_D2, ST_Z1,
    ST_A0, ST_A1, ST_AL, ST_B0, ST_B1, ST_Z2, ST_C0, ST_C1, ST_BT,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_I0, ST_I1, ST_I2, ST_I3, ST_O,
    ST_F0, ST_F1, ST_F2, ST_G0, ST_G1, ST_G2, ST_CR, ST_CF,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_SQ, ST_L0, ST_L1, ST_L2, ST_DONE
  } state_e;

  typedef enum logic [1:0] {MAC_NONE, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_e;

  // Configuration registers.
  logic [14:0] dc_q;
  logic [15:0] k_q;
  logic [23:0] nom_q;
  logic [31:0] ts_q;
  logic [23:0] kp_q;
  logic [27:0] ki_q;

  // Loop state.
  state_e state_q, state_d;
  logic signed [19:0] io_q, io_d, alpha_q, alpha_d, z2_q, z2_d, beta_q, beta_d;
  logic signed [20:0] d_q, d_d, q_q, q_d;
  logic signed [16:0] pi_q, pi_d;
  logic [23:0] omega_q, omega_d;
  logic [15:0] phase_q, phase_d;
  logic signed [15:0] sin_q, sin_d, cos_q, cos_d;
  logic [23:0] flp_q, flp_d;
  logic [19:0] alp_q, alp_d;
  logic [CNT_W-1:0] lc_q, lc_d, uc_q, uc_d;
  logic lock_q, lock_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic [15:0] o_phase_q, o_phase_d;
  logic signed [15:0] o_sin_q, o_sin_d, o_cos_q, o_cos_d;
  logic [23:0] o_rate_q, o_rate_d;
  logic signed [20:0] o_d_q, o_d_d, o_q_q, o_q_d;
  logic [23:0] o_freq_q, o_freq_d;
  logic [19:0] o_amp_q, o_amp_d;
  logic o_lock_q, o_lock_d;

  // Working registers of the sequencer.
  logic [15:0] volts_q, volts_d;
  logic [35:0] wts_q, wts_d, kts_q, kts_d;
  logic signed [23:0] drv_q, drv_d, t1_q, t1_d, ta_q, ta_d, tz_q, tz_d;
  logic signed [16:0] err_q, err_d;
  logic [31:0] inc_q, inc_d;
  logic [23:0] hz_q, hz_d;
  logic [19:0] amp_q, amp_d;
  logic signed [25:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [17:0] cz_q, cz_d;
  logic cneg_q, cneg_d;
  logic [3:0] ci_q, ci_d;
  logic [39:0] sv_q, sv_d, sr_q, sr_d;
  logic [4:0] sk_q, sk_d;

  // Shared multiply-accumulate unit.
  mac_op_e mac_op;
  logic signed [32:0] mac_a;
  logic signed [20:0] mac_b;
  logic mac_sh;
  logic signed [71:0] mac_rnd;
  logic signed [53:0] prod;
  logic signed [71:0] prod_ext, prod_sh, acc_base, acc_q, acc_d;

  assign prod     = mac_a * mac_b;
  assign prod_ext = {{18{prod[53]}}, prod};
  assign prod_sh  = mac_sh ? (prod_ext <<< 20) : prod_ext;
  assign acc_base = (mac_op == MAC_LOAD) ? mac_rnd : acc_q;

  always_comb begin
    case (mac_op)
      MAC_LOAD: acc_d = acc_base + prod_sh;
      MAC_ADD:  acc_d = acc_base + prod_sh;
      MAC_SUB:  acc_d = acc_base - prod_sh;
      default:  acc_d = acc_q;
    endcase
  end

  // APB configuration port.
  logic cfg_wr;
  reg_idx_e cfg_idx;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_DC_OFFSET:     prdata = {17'd0, dc_q};
      REG_SOGI_GAIN:     prdata = {16'd0, k_q};
      REG_NOMINAL_OMEGA: prdata = {8'd0, nom_q};
      REG_SAMPLE_PERIOD: prdata = ts_q;
      REG_PROP_GAIN:     prdata = {8'd0, kp_q};
      REG_INTEG_GAIN:    prdata = {4'd0, ki_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q  <= DC_OFFSET_RST;
      k_q   <= SOGI_GAIN_RST;
      nom_q <= NOMINAL_OMEGA_RST;
      ts_q  <= SAMPLE_PERIOD_RST;
      kp_q  <= PROP_GAIN_RST;
      ki_q  <= INTEG_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DC_OFFSET:     dc_q  <= pwdata[14:0];
        REG_SOGI_GAIN:     k_q   <= pwdata[15:0];
        REG_NOMINAL_OMEGA: nom_q <= pwdata[23:0];
        REG_SAMPLE_PERIOD: ts_q  <= pwdata;
        REG_PROP_GAIN:     kp_q  <= pwdata[23:0];
        REG_INTEG_GAIN:    ki_q  <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer.
  always_comb begin
    logic signed [39:0] vin, ev, sv_t, om, outv;
    logic [25:0] fhz;
    logic [15:0] pn;
    logic signed [17:0] zf;
    logic signed [25:0] dx, dy, xr, yr;
    logic signed [17:0] at;
    logic [39:0] bitv, trial;
    logic inst;
    logic [CNT_W:0] uc_inc;

    vin = '0; ev = '0; sv_t = '0; om = '0; outv = '0; fhz = '0; pn = '0; zf = '0;
    dx = '0; dy = '0; xr = '0; yr = '0; at = '0; bitv = '0; trial = '0;
    inst = 1'b0; uc_inc = '0;

    state_d = state_q;
    io_d = io_q; alpha_d = alpha_q; z2_d = z2_q; beta_d = beta_q;
    d_d = d_q; q_d = q_q; pi_d = pi_q; omega_d = omega_q; phase_d = phase_q;
    sin_d = sin_q; cos_d = cos_q; flp_d = flp_q; alp_d = alp_q;
    lc_d = lc_q; uc_d = uc_q; lock_d = lock_q;
    volts_d = volts_q; wts_d = wts_q; kts_d = kts_q; drv_d = drv_q;
    t1_d = t1_q; ta_d = ta_q; tz_d = tz_q; err_d = err_q; inc_d = inc_q;
    hz_d = hz_q; amp_d = amp_q; cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    cneg_d = cneg_q; ci_d = ci_q; sv_d = sv_q; sr_d = sr_q; sk_d = sk_q;
    o_phase_d = o_phase_q; o_sin_d = o_sin_q; o_cos_d = o_cos_q;
    o_rate_d = o_rate_q; o_d_d = o_d_q; o_q_d = o_q_q; o_freq_d = o_freq_q;
    o_amp_d = o_amp_q; o_lock_d = o_lock_q;
    mac_op = MAC_NONE; mac_a = '0; mac_b = '0; mac_sh = 1'b0; mac_rnd = '0;

    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          volts_d = sample_volts_i;
          state_d = kind_i ? ST_M0 : ST_W0;
        end
      end
      // omega*Ts, Q.24
      ST_W0: begin
        mac_op = MAC_LOAD; mac_a = 33'(nom_q); mac_b = {1'b0, ts_q[19:0]};
        state_d = ST_W1;
      end
      ST_W1: begin
        mac_op = MAC_ADD; mac_a = 33'(nom_q); mac_b = {9'd0, ts_q[31:20]};
        mac_sh = 1'b1; state_d = ST_K0;
      end
      // Ki*Ts, Q.24
      ST_K0: begin
        wts_d = acc_q[55:20];
        mac_op = MAC_LOAD; mac_a = 33'(ki_q); mac_b = {1'b0, ts_q[19:0]};
        state_d = ST_K1;
      end
      ST_K1: begin
        mac_op = MAC_ADD; mac_a = 33'(ki_q); mac_b = {9'd0, ts_q[31:20]};
        mac_sh = 1'b1; state_d = ST_E;
      end
      // Remove offset, clamp, and form k*e.
      ST_E: begin
        kts_d = acc_q[59:24];
        vin = sat_sym($signed({24'd0, volts_q}) - $signed({25'd0, dc_q}), VIN_LIM);
        ev = vin - 40'(alpha_q);
        mac_op = MAC_LOAD; mac_a = 33'(ev); mac_b = {5'd0, k_q};
        state_d = ST_D0;
      end
      ST_D0: begin
        drv_d = 24'(40'(acc_q >>> 14) - 40'(z2_q));
        state_d = ST_D1;
      end
      ST_D1: begin
        mac_op = MAC_LOAD; mac_a = 33'(drv_q); mac_b = {1'b0, wts_q[19:0]};
        state_d = ST_D2;
      end
      ST_D2: begin
        mac_op = MAC_ADD; mac_a = 33'(drv_q); mac_b = {5'd0, wts_q[35:20]};
        mac_sh = 1'b1; state_d = ST_Z1;
      end
      ST_Z1: begin
        t1_d = 24'(sat_sym(40'(acc_q >>> 24) + 40'(io_q), WIDE_LIM));
        state_d = ST_A0;
      end
      ST_A0: begin
        mac_op = MAC_LOAD; mac_a = 33'(t1_q); mac_b = {1'b0, ts_q[19:0]};
        state_d = ST_A1;
      end
      ST_A1: begin
        mac_op = MAC_ADD; mac_a = 33'(t1_q); mac_b = {9'd0, ts_q[31:20]};
        mac_sh = 1'b1; state_d = ST_AL;
      end
      ST_AL: begin
        ta_d = 24'(sat_sym(40'(acc_q >>> 32) + 40'(alpha_q), WIDE_LIM));
        state_d = ST_B0;
      end
      ST_B0: begin
        mac_op = MAC_LOAD; mac_a = 33'(ta_q); mac_b = {1'b0, wts_q[19:0]};
        state_d = ST_B1;
      end
      ST_B1: begin
        mac_op = MAC_ADD; mac_a = 33'(ta_q); mac_b = {5'd0, wts_q[35:20]};
        mac_sh = 1'b1; state_d = ST_Z2;
      end
      ST_Z2: begin
        tz_d = 24'(sat_sym(40'(acc_q >>> 24) + 40'(z2_q), WIDE_LIM));
        state_d = ST_C0;
      end
      ST_C0: begin
        mac_op = MAC_LOAD; mac_a = 33'(tz_q); mac_b = {1'b0, ts_q[19:0]};
        state_d = ST_C1;
      end
      ST_C1: begin
        mac_op = MAC_ADD; mac_a = 33'(tz_q); mac_b = {9'd0, ts_q[31:20]};
        mac_sh = 1'b1; state_d = ST_BT;
      end
      // Commit the integrators with the outer clamp.
      ST_BT: begin
        io_d    = 20'(sat_sym(40'(t1_q), SAT_LIM));
        alpha_d = 20'(sat_sym(40'(ta_q), SAT_LIM));
        z2_d    = 20'(sat_sym(40'(tz_q), SAT_LIM));
        beta_d  = 20'(sat_sym(40'(acc_q >>> 32), SAT_LIM));
        state_d = ST_P0;
      end
      // Park transform with the previous sine and cosine.
      ST_P0: begin
        mac_op = MAC_LOAD; mac_a = 33'(alpha_q); mac_b = 21'(cos_q);
        state_d = ST_P1;
      end
      ST_P1: begin
        mac_op = MAC_ADD; mac_a = 33'(beta_q); mac_b = 21'(sin_q);
        state_d = ST_P2;
      end
      ST_P2: begin
        d_d = 21'(acc_q >>> 15);
        mac_op = MAC_LOAD; mac_a = 33'(beta_q); mac_b = 21'(cos_q);
        state_d = ST_P3;
      end
      ST_P3: begin
        mac_op = MAC_SUB; mac_a = 33'(alpha_q); mac_b = 21'(sin_q);
        state_d = ST_P4;
      end
      ST_P4: begin
        q_d   = 21'(acc_q >>> 15);
        err_d = 17'(sat_sym(40'(acc_q >>> 15), ERR_LIM));
        state_d = ST_I0;
      end
      // PI controller.
      ST_I0: begin
        mac_op = MAC_LOAD; mac_a = 33'(err_q); mac_b = {1'b0, kts_q[19:0]};
        state_d = ST_I1;
      end
      ST_I1: begin
        mac_op = MAC_ADD; mac_a = 33'(err_q); mac_b = {5'd0, kts_q[35:20]};
        mac_sh = 1'b1; state_d = ST_I2;
      end
      ST_I2: begin
        pi_d = 17'(sat_sym(40'(acc_q >>> 24) + 40'(pi_q), ERR_LIM));
        mac_op = MAC_LOAD; mac_a = 33'(err_q); mac_b = {1'b0, kp_q[19:0]};
        state_d = ST_I3;
      end
      ST_I3: begin
        mac_op = MAC_ADD; mac_a = 33'(err_q); mac_b = {17'd0, kp_q[23:20]};
        mac_sh = 1'b1; state_d = ST_O;
      end
      ST_O: begin
        outv = sat_sym(40'(acc_q >>> 16) + 40'(pi_q), OUT_LIM);
        om = $signed({16'd0, nom_q}) + outv;
        if (om < 40'sd0) begin
          omega_d = 24'd0;
        end else if (om > RATE_MAX) begin
          omega_d = 24'hFFFFFF;
        end else begin
          omega_d = om[23:0];
        end
        state_d = ST_F0;
      end
      // Phase increment.
      ST_F0: begin
        mac_op = MAC_LOAD; mac_a = 33'(omega_q); mac_b = {1'b0, ts_q[19:0]};
        state_d = ST_F1;
      end
      ST_F1: begin
        mac_op = MAC_ADD; mac_a = 33'(omega_q); mac_b = {9'd0, ts_q[31:20]};
        mac_sh = 1'b1; state_d = ST_F2;
      end
      ST_F2: begin
        inc_d = acc_q[55:24];
        state_d = ST_G0;
      end
      ST_G0: begin
        mac_op = MAC_LOAD; mac_rnd = RND_PHASE; mac_a = 33'(inc_q);
        mac_b = {1'b0, INV_TWO_PI[19:0]};
        state_d = ST_G1;
      end
      ST_G1: begin
        mac_op = MAC_ADD; mac_a = 33'(inc_q); mac_b = {11'd0, INV_TWO_PI[29:20]};
        mac_sh = 1'b1; state_d = ST_G2;
      end
      // Advance the phase and fold it into the CORDIC range.
      ST_G2: begin
        pn = phase_q + acc_q[51:36];
        phase_d = pn;
        zf = {{2{pn[15]}}, pn};
        cneg_d = 1'b0;
        if (zf > QTR_TURN) begin
          zf = zf - HALF_TURN; cneg_d = 1'b1;
        end else if (zf < -QTR_TURN) begin
          zf = zf + HALF_TURN; cneg_d = 1'b1;
        end
        cz_d = zf; cx_d = CORDIC_X0; cy_d = '0; ci_d = '0;
        state_d = ST_CR;
      end
      ST_CR: begin
        dx = cy_q >>> ci_q;
        dy = cx_q >>> ci_q;
        at = $signed({4'd0, atan_turn(ci_q)});
        if (cz_q >= 18'sd0) begin
          cx_d = cx_q - dx; cy_d = cy_q + dy; cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + dx; cy_d = cy_q - dy; cz_d = cz_q + at;
        end
        ci_d = ci_q + 4'd1;
        if (ci_q == CORDIC_LAST) begin
          state_d = ST_CF;
        end
      end
      ST_CF: begin
        xr = (cx_q + 26'sd128) >>> 8;
        yr = (cy_q + 26'sd128) >>> 8;
        if (cneg_q) begin
          xr = -xr; yr = -yr;
        end
        cos_d = 16'(sat_sym(40'(xr), TRIG_LIM));
        sin_d = 16'(sat_sym(40'(yr), TRIG_LIM));
        state_d = ST_DONE;
      end
      // Monitor: raw frequency in Hz.
      ST_M0: begin
        mac_op = MAC_LOAD; mac_rnd = RND_HZ; mac_a = 33'(omega_q);
        mac_b = {1'b0, INV_TWO_PI[19:0]};
        state_d = ST_M1;
      end
      ST_M1: begin
        mac_op = MAC_ADD; mac_a = 33'(omega_q); mac_b = {11'd0, INV_TWO_PI[29:20]};
        mac_sh = 1'b1; state_d = ST_M2;
      end
      ST_M2: begin
        fhz = acc_q[53:28];
        hz_d = (fhz[25:24] != 2'd0) ? 24'hFFFFFF : fhz[23:0];
        mac_op = MAC_LOAD; mac_a = 33'(alpha_q); mac_b = 21'(alpha_q);
        state_d = ST_M3;
      end
      ST_M3: begin
        mac_op = MAC_ADD; mac_a = 33'(beta_q); mac_b = 21'(beta_q);
        state_d = ST_M4;
      end
      ST_M4: begin
        sv_d = {1'b0, acc_q[38:0]};
        sr_d = '0; sk_d = SQRT_TOP;
        state_d = ST_SQ;
      end
      // Integer square root, one bit pair a cycle.
      ST_SQ: begin
        bitv = 40'd1 << {sk_q, 1'b0};
        trial = sr_q + bitv;
        if (sv_q >= trial) begin
          sv_d = sv_q - trial;
          sr_d = (sr_q >> 1) + bitv;
        end else begin
          sr_d = sr_q >> 1;
        end
        sk_d = sk_q - 5'd1;
        if (sk_q == 5'd0) begin
          state_d = ST_L0;
        end
      end
      ST_L0: begin
        amp_d = sr_q[19:0];
        sv_t = $signed({16'd0, hz_q}) - $signed({16'd0, flp_q});
        mac_op = MAC_LOAD; mac_a = 33'(sv_t); mac_b = FREQ_ALPHA;
        state_d = ST_L1;
      end
      ST_L1: begin
        flp_d = 24'($signed({16'd0, flp_q}) + 40'(acc_q >>> 16));
        sv_t = $signed({20'd0, amp_q}) - $signed({20'd0, alp_q});
        mac_op = MAC_LOAD; mac_a = 33'(sv_t); mac_b = AMP_ALPHA;
        state_d = ST_L2;
      end
      // Filtered amplitude and the lock detector.
      ST_L2: begin
        alp_d = 20'($signed({20'd0, alp_q}) + 40'(acc_q >>> 16));
        inst = (q_q < VQ_LIM) && (q_q > -VQ_LIM) && (hz_q >= FREQ_LO) &&
               (hz_q <= FREQ_HI) && (amp_q >= AMP_MIN);
        if (inst) begin
          if (lc_q < LOCK_VAL) begin
            lc_d = lc_q + CNT_W'(1);
          end
          if (lc_d >= LOCK_VAL) begin
            lock_d = 1'b1;
          end
        end else if (lock_q) begin
          uc_inc = {1'b0, uc_q} + (CNT_W+1)'(1);
          if (uc_inc >= {1'b0, LOCK_VAL}) begin
            lc_d = '0; lock_d = 1'b0; uc_d = '0;
          end else begin
            uc_d = uc_inc[CNT_W-1:0];
          end
        end else if (lc_q != '0) begin
          lc_d = lc_q - CNT_W'(1);
        end
        state_d = ST_DONE;
      end
      // Hand the result over once the output register is free.
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_phase_d = phase_q; o_sin_d = sin_q; o_cos_d = cos_q;
          o_rate_d = omega_q; o_d_d = d_q; o_q_d = q_q; o_freq_d = flp_q;
          o_amp_d = alp_q; o_lock_d = lock_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      io_q <= '0; alpha_q <= '0; z2_q <= '0; beta_q <= '0;
      d_q <= '0; q_q <= '0; pi_q <= '0;
      omega_q <= NOMINAL_OMEGA_RST;
      phase_q <= '0; sin_q <= '0; cos_q <= 16'sd32767;
      flp_q <= FREQ_RST; alp_q <= '0;
      lc_q <= '0; uc_q <= '0; lock_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      io_q <= io_d; alpha_q <= alpha_d; z2_q <= z2_d; beta_q <= beta_d;
      d_q <= d_d; q_q <= q_d; pi_q <= pi_d;
      omega_q <= omega_d;
      phase_q <= phase_d; sin_q <= sin_d; cos_q <= cos_d;
      flp_q <= flp_d; alp_q <= alp_d;
      lc_q <= lc_d; uc_q <= uc_d; lock_q <= lock_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    volts_q <= volts_d; wts_q <= wts_d; kts_q <= kts_d; drv_q <= drv_d;
    t1_q <= t1_d; ta_q <= ta_d; tz_q <= tz_d; err_q <= err_d; inc_q <= inc_d;
    hz_q <= hz_d; amp_q <= amp_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; cneg_q <= cneg_d; ci_q <= ci_d;
    sv_q <= sv_d; sr_q <= sr_d; sk_q <= sk_d;
    o_phase_q <= o_phase_d; o_sin_q <= o_sin_d; o_cos_q <= o_cos_d;
    o_rate_q <= o_rate_d; o_d_q <= o_d_d; o_q_q <= o_q_d;
    o_freq_q <= o_freq_d; o_amp_q <= o_amp_d; o_lock_q <= o_lock_d;
  end

  assign out_valid_o    = out_valid_q;
  assign phase_o        = o_phase_q;
  assign sine_o         = o_sin_q;
  assign cosine_o       = o_cos_q;
  assign angular_rate_o = o_rate_q;
  assign direct_comp_o  = o_d_q;
  assign quad_comp_o    = o_q_q;
  assign freq_hz_o      = o_freq_q;
  assign amplitude_o    = o_amp_q;
  assign locked_o       = o_lock_q;

  // The lock flag is only ever set once the lock counter has filled.
  a_lock_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |-> (lc_q == LOCK_VAL))
    else $error("lock flag set without a full lock count");

  // The unlock counter clears before it reaches the threshold.
  a_unlock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc_q < LOCK_VAL)
    else $error("unlock counter reached its threshold");

  // The first two SOGI integrators, io and alpha, stay within the outer clamp.
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (io_q <= 20'sd409600) && (io_q >= -20'sd409600) &&
    (alpha_q <= 20'sd409600) && (alpha_q >= -20'sd409600))
    else $error("SOGI integrator outside its clamp");

  // A result only appears from the final sequencer state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("output beat raised outside the final state");

  // An accepted beat always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted beat did not start the sequencer");

endmodule
